// File: sv/ovl_pkg.sv
// Shared types and codes for the ordered value list.
// Holds operation and status codes plus the controller/datapath command and status structs.
// No dependencies.
package ovl_pkg;

  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LIST   = 2'd2
  } ovl_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5
  } ovl_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_in;     // capture the value of the accepted beat
    logic        idx_zero;    // restart the walk index at the head
    logic        idx_inc;     // advance the walk index
    logic        wr_ins;      // write the captured value at the tail
    logic        wr_shift;    // move the entry under the index up one place
    logic        cnt_inc;
    logic        cnt_dec;
    logic        emit;        // load the result register
    logic        emit_listed; // result carries the entry under the index
    logic        emit_last;
    ovl_status_t emit_status;
  } ovl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_last;  // index points at the tail entry
    logic idx_end;   // index has moved past the tail
    logic match;     // entry under the index equals the captured value
    logic out_free;  // result register can take a new beat this cycle
  } ovl_sts_t;

endpackage

// File: sv/ovl_if.sv
// Valid/ready channel interfaces for the ordered value list.
// Depends on ovl_pkg for field widths.
interface ovl_in_if import ovl_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ovl_out_if import ovl_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  entry;
  logic                       last;

  modport source (output valid, output status, output entry, output last, input ready);
  modport sink   (input valid, input status, input entry, input last, output ready);
endinterface

// File: sv/ovl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ovl_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/ovl_dp.sv
// Datapath of the ordered value list: entry store, count, walk index and result register.
// Depends on ovl_pkg and ovl_ram; driven by ovl_ctrl through ovl_cmd_t.
module ovl_dp import ovl_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [VALUE_W-1:0] in_value,
  input  ovl_cmd_t                  cmd,
  output ovl_sts_t                  sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_entry,
  output logic                      out_last
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt, idx_m1;
  logic [VALUE_W-1:0] value_r;
  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0] out_entry_r;
  logic               out_last_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // The read address follows the next index so the data lines up with idx_r.
  assign rd_addr = (idx_nxt < CW'(LIST_DEPTH)) ? idx_nxt[AW-1:0] : '0;
  assign idx_m1  = idx_r - CW'(1);
  assign wr_en   = cmd.wr_ins | cmd.wr_shift;
  assign wr_addr = cmd.wr_ins ? count_r[AW-1:0] : idx_m1[AW-1:0];
  assign wr_data = cmd.wr_ins ? value_r : rd_data;

  ovl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LIST_DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value_r <= in_value;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_entry_r  <= cmd.emit_listed ? rd_data : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.full       = (count_r == CW'(LIST_DEPTH));
    sts.idx_last   = ((idx_r + CW'(1)) == count_r);
    sts.idx_end    = (idx_r == count_r);
    sts.match      = (rd_data == value_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("entry count exceeds the list depth");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ins |-> !sts.full)
    else $error("insert written into a full list");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten before it was taken");

  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (!sts.count_zero && $past(cmd.idx_inc || cmd.wr_shift)))
    else $error("count decremented without a completed delete");
`endif

endmodule

// File: sv/ovl_ctrl.sv
// Controller of the ordered value list: sequences insert, delete and list operations.
// Depends on ovl_pkg; commands ovl_dp through ovl_cmd_t and reads ovl_sts_t.
module ovl_ctrl import ovl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  ovl_sts_t          sts,
  output ovl_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SRCH,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  state_t      state_r, state_nxt;
  ovl_status_t resp_r, resp_nxt;
  logic        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in  = 1'b1;
          cmd.idx_zero = 1'b1;
          case (in_kind)
            KIND_INSERT: begin
              if (sts.full) begin
                resp_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_INS;
              end
            end
            KIND_DELETE: begin
              if (sts.count_zero) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            KIND_LIST: begin
              if (sts.count_zero) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        cmd.wr_ins  = 1'b1;
        cmd.cnt_inc = 1'b1;
        resp_nxt    = ST_INSERTED;
        state_nxt   = S_RESP;
      end
      S_SRCH: begin
        if (sts.match) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SHIFT;
        end else if (sts.idx_last) begin
          resp_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.idx_end) begin
          cmd.cnt_dec = 1'b1;
          resp_nxt    = ST_DELETED;
          state_nxt   = S_RESP;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_listed = 1'b1;
          cmd.emit_status = ST_LISTED;
          cmd.emit_last   = sts.idx_last;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = resp_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

// File: sv/ordered_value_list.sv
// Top level of the ordered value list: joins controller, datapath and the two channels.
// Depends on ovl_pkg, ovl_if, ovl_ctrl and ovl_dp (which holds the ovl_ram store).
//
// The block keeps up to LIST_DEPTH signed 32-bit values in the order they were inserted.
// Each input beat carries a kind and a value. An insert appends the value at the tail and
// returns one beat with status inserted, or list full when LIST_DEPTH values are held. A
// delete removes the first value, counted from the head, that equals the given value bit
// for bit, and moves every value behind it up one place so the order is kept; it returns
// deleted, not found or list empty. A list request returns one beat per held value, from
// head to tail, with status entry listed and the value in entry, or one list empty beat.
// The last flag is set on the final beat of every request, and kind code 3 is dropped
// without any result. The input channel takes one request at a time: ready is high only
// while no request is in progress, but a request may be taken while the previous result
// still waits in the output register. All entries sit in a single RAM with one write and
// one registered read port, and that read port sets the pace: an insert passes through
// S_INS and then S_RESP before its result is offered, a delete walks the index through
// S_SRCH from the head and, on a match, through S_SHIFT to the tail before S_RESP, and a
// list streams one entry per cycle whenever the sink keeps ready high.
// There is no clearing pass after reset; only entries below the count are ever used.
module ordered_value_list import ovl_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ovl_in_if.sink    in_ch,
  ovl_out_if.source out_ch
);

  ovl_cmd_t cmd;
  ovl_sts_t sts;

  // Sequencer: decides per request which datapath steps run and when results are loaded.
  ovl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_kind (in_ch.kind),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Store, count, walk index and output register; the output register decouples the sink.
  ovl_dp #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_status(out_ch.status),
    .out_entry (out_ch.entry),
    .out_last  (out_ch.last)
  );

endmodule
